[rtl/core/ndsf_pkg.sv]
`timescale 1ns / 1ps

package ndsf_pkg;

  // coordinate and segment geometry
  localparam int COORD_W   = 15;
  localparam int NUM_COORD = 4;
  localparam int SEG_W     = COORD_W * NUM_COORD;

  // tolerance register
  localparam int            TOL_W     = 14;
  localparam logic [13:0]   TOL_RESET = 14'd48;

  // reported slot number width
  localparam int SLOT_W = 6;

  // default table size
  localparam int TABLE_DEPTH_DEFAULT = 64;

  // stream word widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // control sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PEND
  } ndsf_state_t;

endpackage

[rtl/core/ndsf_seg_ram.sv]
`timescale 1ns / 1ps

module ndsf_seg_ram
  import ndsf_pkg::*;
#(
  parameter int DEPTH  = TABLE_DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SEG_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SEG_W-1:0]  rd_data
);

  logic [SEG_W-1:0] mem [DEPTH];
  logic [SEG_W-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/ndsf_match.sv]
`timescale 1ns / 1ps

module ndsf_match
  import ndsf_pkg::*;
(
  input  logic [SEG_W-1:0] seg,
  input  logic [SEG_W-1:0] entry,
  input  logic [TOL_W-1:0] tol,
  output logic             near
);

  logic [NUM_COORD-1:0] close;

  // per coordinate: |a - b| < tol
  for (genvar k = 0; k < NUM_COORD; k++) begin : g_coord
    logic signed [COORD_W:0] diff;
    logic        [COORD_W:0] mag;

    assign diff = {seg[k*COORD_W + COORD_W-1], seg[k*COORD_W +: COORD_W]}
                - {entry[k*COORD_W + COORD_W-1], entry[k*COORD_W +: COORD_W]};
    assign mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
    assign close[k] = mag < {{(COORD_W + 1 - TOL_W){1'b0}}, tol};
  end

  assign near = &close;

endmodule

[rtl/core/near_duplicate_segment_filter_unit.sv]
`timescale 1ns / 1ps
// sequence: each accepted word is compared with the kept entries in slot order, stopping at
//   the first near duplicate; the fill scanned is the one after an optional start_list clear
// throughput: one entry read per cycle from the segment memory, one segment in flight;
//   the next word is accepted only after the result has been handed to the output register
// reset: synchronous active-low rst_n empties the table (fill count to zero), sets
//   match_tolerance to 48 and clears the output; memory contents are not cleared

module near_duplicate_segment_filter_unit
  import ndsf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [TOL_W-1:0]      cfg_wr_data,
  // input segments
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x_start, y_start, x_end, y_end, zero pad
  input  logic                  in_tuser,   // start_list
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // slot_index, zero pad
  output logic [1:0]            out_tuser   // kept, table_overflow
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  ndsf_state_t state_r, state_nxt;

  logic [TOL_W-1:0]  tol_r;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic              res_kept_r, res_kept_nxt;
  logic              res_ovf_r, res_ovf_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kept_r, out_kept_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;

  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [SEG_W-1:0]  mem_rd_data;
  logic              hit;
  logic              in_fire;
  logic              out_free;

  // segment table
  ndsf_seg_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (seg_r),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_idx_r[ADDR_W-1:0]),
    .rd_data (mem_rd_data)
  );

  // closeness test against the entry read last cycle
  ndsf_match u_match (
    .seg   (seg_r),
    .entry (mem_rd_data),
    .tol   (tol_r),
    .near  (hit)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - SLOT_W){1'b0}}, out_slot_r};
  assign out_tuser  = {out_ovf_r, out_kept_r};

  // scan sequencer and result staging
  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    res_kept_nxt  = res_kept_r;
    res_ovf_nxt   = res_ovf_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_kept_nxt  = out_kept_r;
    out_ovf_nxt   = out_ovf_r;
    out_slot_nxt  = out_slot_r;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          seg_nxt    = in_tdata[SEG_W-1:0];
          rd_idx_nxt = '0;
          if (in_tuser) begin
            count_nxt = '0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (cmp_valid_r && hit) begin
          // near duplicate of a stored entry
          res_kept_nxt = 1'b0;
          res_ovf_nxt  = 1'b0;
          res_slot_nxt = SLOT_W'(cmp_idx_r);
          state_nxt    = ST_PEND;
        end else if (rd_idx_r < count_r) begin
          // read the next stored entry
          mem_rd_en     = 1'b1;
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = rd_idx_r[ADDR_W-1:0];
          rd_idx_nxt    = rd_idx_r + 1'b1;
        end else if (count_r < DEPTH_C) begin
          // new segment, append
          mem_wr_en    = 1'b1;
          res_kept_nxt = 1'b1;
          res_ovf_nxt  = 1'b0;
          res_slot_nxt = SLOT_W'(count_r);
          count_nxt    = count_r + 1'b1;
          state_nxt    = ST_PEND;
        end else begin
          // new segment, table full
          res_kept_nxt = 1'b1;
          res_ovf_nxt  = 1'b1;
          res_slot_nxt = '0;
          state_nxt    = ST_PEND;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kept_nxt  = res_kept_r;
          out_ovf_nxt   = res_ovf_r;
          out_slot_nxt  = res_slot_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    seg_r      <= seg_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_kept_r <= res_kept_nxt;
    res_ovf_r  <= res_ovf_nxt;
    res_slot_r <= res_slot_nxt;
    out_kept_r <= out_kept_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_slot_r <= out_slot_nxt;
  end

endmodule

[tb/tb_near_duplicate_segment_filter_unit.sv]
`timescale 1ns / 1ps

module tb_near_duplicate_segment_filter_unit;
  import ndsf_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEFAULT;
  localparam int DIR_ROWS    = 24;
  localparam int PHASE_WORDS = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_PCT    = 38;

  // one segment, x_start in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] ye;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xs;
  } seg_t;

  // filter decision for one segment
  typedef struct packed {
    logic              kept;
    logic [SLOT_W-1:0] slot;
    logic              ovf;
  } verdict_t;

  typedef enum logic {ROW_SEGMENT, ROW_SET_TOL} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              start;
    logic [TOL_W-1:0]  tol;
    int                xs;
    int                ys;
    int                xe;
    int                ye;
    logic              fixed_exp;
    logic              kept;
    logic [SLOT_W-1:0] slot;
    logic              ovf;
  } dir_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [TOL_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  // shadow of the block state
  seg_t             kept_tab [DEPTH];
  int               kept_fill = 0;
  logic [TOL_W-1:0] tol_q     = TOL_RESET;

  verdict_t pending_verdicts [$];
  seg_t     list_hist [$];
  int       err_cnt      = 0;
  int       quiet_cycles = 0;
  bit       steady_flow  = 1'b0;
  bit       hold_req     = 1'b0;
  int       hold_left    = 0;

  // directed rows: fixed expectations only where obvious
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_SEGMENT, 1'b1, 14'd0, 0, 0, 0, 0, 1'b1, 1'b1, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 10, 10, 10, 10, 1'b1, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 47, -47, 47, -47, 1'b1, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 48, 0, 0, 0, 1'b1, 1'b1, 6'd1, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 16383, 16383, 16383, 16383, 1'b1, 1'b1, 6'd2, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, -16384, -16384, -16384, -16384, 1'b1, 1'b1, 6'd3, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 16383, -16384, 16383, -16384, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, -16384, 16383, -16384, 16383, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 16380, 16383, 16383, 16383, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b1, 14'd0, 16383, 16383, 16383, 16383, 1'b1, 1'b1, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 0, 0, 0, 0, 1'b1, 1'b1, 6'd1, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 5, 0, 0, 0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b1, 14'd0, 0, 0, 0, 0, 1'b1, 1'b1, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 60, 0, 0, 0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 30, 0, 0, 0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 59, 0, 0, 0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SET_TOL, 1'b0, 14'd0, 0, 0, 0, 0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b1, 14'd0, 0, 0, 0, 0, 1'b1, 1'b1, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 0, 0, 0, 0, 1'b1, 1'b1, 6'd1, 1'b0},
    '{ROW_SET_TOL, 1'b0, 14'd16383, 0, 0, 0, 0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b1, 14'd0, 16383, 16383, 16383, 16383, 1'b1, 1'b1, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, -16384, -16384, -16384, -16384, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 1, 1, 1, 1, 1'b0, 1'b0, 6'd0, 1'b0},
    '{ROW_SEGMENT, 1'b0, 14'd0, 0, 0, 0, 0, 1'b0, 1'b0, 6'd0, 1'b0}
  };

  near_duplicate_segment_filter_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // per-coordinate closeness, strict below the tolerance
  function automatic bit coord_close(input logic signed [COORD_W-1:0] a,
                                     input logic signed [COORD_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d < int'(tol_q);
  endfunction

  // first matching kept entry wins, otherwise append or flag overflow
  function automatic verdict_t filter_segment(input logic start, input seg_t s);
    verdict_t v;
    bit       hit;
    if (start) kept_fill = 0;
    v   = '0;
    hit = 1'b0;
    for (int i = 0; i < kept_fill && !hit; i++) begin
      if (coord_close(s.xs, kept_tab[i].xs) && coord_close(s.ys, kept_tab[i].ys) &&
          coord_close(s.xe, kept_tab[i].xe) && coord_close(s.ye, kept_tab[i].ye)) begin
        hit    = 1'b1;
        v.slot = i[SLOT_W-1:0];
      end
    end
    if (!hit) begin
      v.kept = 1'b1;
      if (kept_fill < DEPTH) begin
        kept_tab[kept_fill] = s;
        v.slot              = kept_fill[SLOT_W-1:0];
        kept_fill++;
      end else begin
        v.ovf = 1'b1;
      end
    end
    return v;
  endfunction

  // mix of extremes, a small cluster near the origin and full range
  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return 15'h3FFF;
        1:       return 15'h4000;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 40) return 15'(int'($urandom_range(0, 400)) - 200);
    return 15'($urandom_range(0, 32767));
  endfunction

  // move a coordinate by up to the tolerance, often right at the boundary
  function automatic logic [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] c);
    int t;
    int d;
    int v;
    t = int'(tol_q);
    case ($urandom_range(0, 3))
      0:       d = int'($urandom_range(0, 2 * t)) - t;
      1:       d = t - 1;
      2:       d = t;
      default: d = 0;
    endcase
    if ($urandom_range(0, 1) == 1) d = -d;
    v = int'(c) + d;
    if (v > 16383) v = 16383;
    if (v < -16384) v = -16384;
    return v[COORD_W-1:0];
  endfunction

  // fresh segment, exact repeat or near copy of one sent earlier in the list
  function automatic seg_t make_segment();
    seg_t s;
    seg_t base;
    int   roll;
    roll = $urandom_range(0, 99);
    if (list_hist.size() == 0 || roll < 45) begin
      s.xs = rand_coord();
      s.ys = rand_coord();
      s.xe = rand_coord();
      s.ye = rand_coord();
    end else begin
      base = list_hist[$urandom_range(0, list_hist.size() - 1)];
      if (roll < 55) begin
        s = base;
      end else begin
        s.xs = nudge(base.xs);
        s.ys = nudge(base.ys);
        s.xe = nudge(base.xe);
        s.ye = nudge(base.ye);
      end
    end
    return s;
  endfunction

  // offer one word, called at a falling edge, returns at a falling edge
  task automatic send_word(input logic start, input seg_t s, input bit fixed_exp,
                           input verdict_t fixed_v);
    verdict_t v;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - SEG_W){1'b0}}, s};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = filter_segment(start, s);
    pending_verdicts = {pending_verdicts, (fixed_exp ? fixed_v : v)};
    @(negedge clk);
  endtask

  // stop offering and wait until the block has answered everything
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tol(input logic [TOL_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tol_q = v;
  endtask

  // lists opened by start_list, with some that run past the table size
  task automatic run_phase(input int n_words);
    int   sent;
    int   len;
    bit   first;
    logic start;
    seg_t s;
    sent  = 0;
    first = 1'b1;
    while (sent < n_words) begin
      if (first) len = $urandom_range(66, 72);
      else if ($urandom_range(0, 99) < 12) len = $urandom_range(60, 70);
      else len = $urandom_range(1, 12);
      for (int j = 0; j < len; j++) begin
        if (j == 0) start = first || ($urandom_range(0, 99) >= 5);
        else start = ($urandom_range(0, 99) < 3);
        if (start) list_hist.delete();
        s = make_segment();
        list_hist = {list_hist, s};
        send_word(start, s, 1'b0, '0);
      end
      sent += len;
      first = 1'b0;
    end
  endtask

  // result receiver with random stalls and an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word: slot_index %0d", out_tdata[SLOT_W-1:0]);
        err_cnt++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser[0] !== want.kept) begin
          $error("kept: expected %0b, got %0b", want.kept, out_tuser[0]);
          err_cnt++;
        end
        if (out_tdata[SLOT_W-1:0] !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_tdata[SLOT_W-1:0]);
          err_cnt++;
        end
        if (out_tuser[1] !== want.ovf) begin
          $error("table_overflow: expected %0b, got %0b", want.ovf, out_tuser[1]);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    logic [TOL_W-1:0] phase_tol [6];
    seg_t             s;
    phase_tol = '{14'd0, 14'd48, 14'd16383, 14'd1, 14'($urandom_range(2, 400)), 14'd48};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed words at the reset tolerance, then zero and full-scale tolerance
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_SET_TOL) begin
        settle();
        write_tol(dir_tab[r].tol);
      end else begin
        s.xs = dir_tab[r].xs[COORD_W-1:0];
        s.ys = dir_tab[r].ys[COORD_W-1:0];
        s.xe = dir_tab[r].xe[COORD_W-1:0];
        s.ye = dir_tab[r].ye[COORD_W-1:0];
        send_word(dir_tab[r].start, s, dir_tab[r].fixed_exp,
                  verdict_t'{dir_tab[r].kept, dir_tab[r].slot, dir_tab[r].ovf});
      end
    end

    // random phases, each at its own tolerance
    for (int p = 0; p < 6; p++) begin
      settle();
      write_tol(phase_tol[p]);
      list_hist.delete();
      steady_flow = (p == 5);
      if (p == 2) hold_req = 1'b1;
      run_phase(PHASE_WORDS);
    end

    settle();
    repeat (80) @(negedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ndsf_pkg.sv
rtl/core/ndsf_seg_ram.sv
rtl/core/ndsf_match.sv
rtl/core/near_duplicate_segment_filter_unit.sv
tb/tb_near_duplicate_segment_filter_unit.sv
